// ----- design/psc_pkg.sv -----
// psc_pkg: payload structs, calibration word layout, register indexes and
// pipeline stage counts for the pressure sensor compensation block
// no dependencies
`default_nettype none

package psc_pkg;

  localparam int RAW_W     = 24;
  localparam int CAL_W     = 16;
  localparam int TEMP_W    = 19;
  localparam int PRES_W    = 32;
  localparam int CFG_IDX_W = 3;

  // calibration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_SENS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_OFF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_TC    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_TC     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_REF   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_COEFF = 3'd5;

  // band limits in 0.01 degC
  localparam int TEMP_HIGH_LIMIT = 2000;
  localparam int TEMP_VLOW_LIMIT = -1500;

  // pipeline split
  localparam int FIRST_STAGES  = 3;
  localparam int SECOND_STAGES = 3;
  localparam int PRESS_STAGES  = 5;
  localparam int NUM_STAGES    = FIRST_STAGES + SECOND_STAGES + PRESS_STAGES;

  typedef struct packed {
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;
  } in_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature_centi;
    logic signed [PRES_W-1:0] pressure_decimbar;
  } out_t;

  typedef struct packed {
    logic [CAL_W-1:0] press_sens;
    logic [CAL_W-1:0] press_off;
    logic [CAL_W-1:0] sens_tc;
    logic [CAL_W-1:0] off_tc;
    logic [CAL_W-1:0] temp_ref;
    logic [CAL_W-1:0] temp_coeff;
  } cal_t;

  // first-order terms
  typedef struct packed {
    logic [RAW_W-1:0]  d1;
    logic signed [19:0] t;
    logic signed [19:0] tm;
    logic signed [19:0] tp;
    logic signed [36:0] off;
    logic signed [35:0] sens;
    logic [16:0]        ti_low;
    logic [11:0]        ti_high;
  } first_t;

  // corrected terms
  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic signed [TEMP_W-1:0] temp;
    logic signed [41:0]       off;
    logic signed [41:0]       sens;
  } second_t;

endpackage

`default_nettype wire

// ----- design/psc_ctrl.sv -----
// psc_ctrl: per-stage valid bits and stage enables of the pipeline
// depends on psc_pkg
`default_nettype none

module psc_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            out_ready,
  output logic                            in_ready,
  output logic                            out_valid,
  output logic [psc_pkg::NUM_STAGES-1:0]  en
);
  import psc_pkg::*;

  logic [NUM_STAGES-1:0] v;

  // a stage loads when it is empty or its contents move on
  always_comb begin
    en[NUM_STAGES-1] = !v[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NUM_STAGES-1];

endmodule

`default_nettype wire

// ----- design/psc_first.sv -----
// psc_first: three stages for dT, the four products and the first-order
// temperature, offset and sensitivity terms
// depends on psc_pkg
`default_nettype none

module psc_first (
  input  logic                              clk,
  input  logic [psc_pkg::FIRST_STAGES-1:0]  en,
  input  psc_pkg::in_t                      in_data,
  input  psc_pkg::cal_t                     cal,
  output psc_pkg::first_t                   res
);
  import psc_pkg::*;

  // stage a
  logic [RAW_W-1:0]   d1_a;
  logic signed [24:0] dt_a;

  // stage b
  logic [RAW_W-1:0]   d1_b;
  logic signed [41:0] prod_t_b;
  logic signed [41:0] prod_off_b;
  logic signed [41:0] prod_sens_b;
  logic [47:0]        dtsq_b;

  logic signed [41:0] dt_x;
  logic signed [49:0] dtsq_full;

  logic signed [41:0] t_adj;
  logic signed [41:0] off_adj;
  logic signed [41:0] sens_adj;
  logic signed [19:0] tq;
  logic [49:0]        dtsq3;
  first_t             res_next;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d1_a <= in_data.raw_pressure;
      dt_a <= $signed({1'b0, in_data.raw_temperature})
            - $signed({1'b0, cal.temp_ref, 8'h00});
    end
  end

  always_comb begin
    dt_x      = 42'(dt_a);
    dtsq_full = 50'(dt_a) * 50'(dt_a);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      d1_b        <= d1_a;
      prod_t_b    <= dt_x * $signed({26'd0, cal.temp_coeff});
      prod_off_b  <= dt_x * $signed({26'd0, cal.off_tc});
      prod_sens_b <= dt_x * $signed({26'd0, cal.sens_tc});
      dtsq_b      <= dtsq_full[47:0];
    end
  end

  // divisions by powers of two, truncated toward zero
  always_comb begin
    t_adj    = prod_t_b + (prod_t_b[41] ? 42'sd8388607 : 42'sd0);
    off_adj  = prod_off_b + (prod_off_b[41] ? 42'sd127 : 42'sd0);
    sens_adj = prod_sens_b + (prod_sens_b[41] ? 42'sd255 : 42'sd0);
    tq       = 20'(t_adj >>> 23);
    dtsq3    = {2'b00, dtsq_b} + {1'b0, dtsq_b, 1'b0};

    res_next.d1      = d1_b;
    res_next.tm      = tq;
    res_next.t       = tq + 20'(TEMP_HIGH_LIMIT);
    res_next.tp      = tq + 20'(TEMP_HIGH_LIMIT - TEMP_VLOW_LIMIT);
    res_next.off     = $signed({5'd0, cal.press_off, 16'd0}) + 37'(off_adj >>> 7);
    res_next.sens    = $signed({5'd0, cal.press_sens, 15'd0}) + 36'(sens_adj >>> 8);
    res_next.ti_low  = dtsq3[49:33];
    res_next.ti_high = dtsq_b[47:36];
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/psc_second.sv -----
// psc_second: three stages for the band squares, the output temperature and
// the second-order offset and sensitivity corrections
// depends on psc_pkg
`default_nettype none

module psc_second (
  input  logic                               clk,
  input  logic [psc_pkg::SECOND_STAGES-1:0]  en,
  input  psc_pkg::first_t                    f,
  output psc_pkg::second_t                   res
);
  import psc_pkg::*;

  // stage d
  logic [RAW_W-1:0]         d1_d;
  logic signed [TEMP_W-1:0] temp_d;
  logic signed [36:0]       off_d;
  logic signed [35:0]       sens_d;
  logic [35:0]              sq_m_d;
  logic [35:0]              sq_p_d;
  logic                     low_d;
  logic                     vlow_d;

  // stage e
  logic [RAW_W-1:0]         d1_e;
  logic signed [TEMP_W-1:0] temp_e;
  logic signed [36:0]       off_e;
  logic signed [35:0]       sens_e;
  logic [39:0]              offi_e;
  logic [39:0]              sensi_e;

  logic signed [39:0] sq_m_full;
  logic signed [39:0] sq_p_full;
  logic [16:0]        ti;
  logic signed [19:0] t_full;

  logic [39:0] m3;
  logic [39:0] m5;
  logic [39:0] p7;
  logic [39:0] p4;
  logic [39:0] offi_next;
  logic [39:0] sensi_next;

  always_comb begin
    sq_m_full = 40'(f.tm) * 40'(f.tm);
    sq_p_full = 40'(f.tp) * 40'(f.tp);
    ti        = f.tm[19] ? f.ti_low : {5'd0, f.ti_high};
    t_full    = f.t - $signed({3'b000, ti});
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d1_d   <= f.d1;
      temp_d <= t_full[TEMP_W-1:0];
      off_d  <= f.off;
      sens_d <= f.sens;
      sq_m_d <= sq_m_full[35:0];
      sq_p_d <= sq_p_full[35:0];
      low_d  <= f.tm[19];
      vlow_d <= f.tp[19];
    end
  end

  always_comb begin
    m3 = 40'(sq_m_d) + (40'(sq_m_d) << 1);
    m5 = 40'(sq_m_d) + (40'(sq_m_d) << 2);
    p7 = (40'(sq_p_d) << 3) - 40'(sq_p_d);
    p4 = 40'(sq_p_d) << 2;
    if (low_d) begin
      offi_next  = (m3 >> 1) + (vlow_d ? p7 : 40'd0);
      sensi_next = (m5 >> 3) + (vlow_d ? p4 : 40'd0);
    end else begin
      offi_next  = 40'(sq_m_d >> 4);
      sensi_next = 40'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      d1_e    <= d1_d;
      temp_e  <= temp_d;
      off_e   <= off_d;
      sens_e  <= sens_d;
      offi_e  <= offi_next;
      sensi_e <= sensi_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      res.d1   <= d1_e;
      res.temp <= temp_e;
      res.off  <= 42'(off_e) - $signed({2'b00, offi_e});
      res.sens <= 42'(sens_e) - $signed({2'b00, sensi_e});
    end
  end

endmodule

`default_nettype wire

// ----- design/psc_press.sv -----
// psc_press: five stages for the split pressure product, the two truncating
// scalings, the offset subtraction and the 32-bit saturation
// depends on psc_pkg
`default_nettype none

module psc_press (
  input  logic                              clk,
  input  logic [psc_pkg::PRESS_STAGES-1:0]  en,
  input  psc_pkg::second_t                  s,
  output psc_pkg::out_t                     res
);
  import psc_pkg::*;

  localparam logic signed [47:0] P_MAX = 48'sd2147483647;
  localparam logic signed [47:0] P_MIN = -48'sd2147483648;

  // stage g
  logic signed [TEMP_W-1:0] temp_g;
  logic signed [41:0]       off_g;
  logic [44:0]              pp_lo_g;
  logic signed [45:0]       pp_hi_g;

  // stage h
  logic signed [TEMP_W-1:0] temp_h;
  logic signed [41:0]       off_h;
  logic signed [66:0]       prod_h;

  // stage i
  logic signed [TEMP_W-1:0] temp_i;
  logic signed [41:0]       off_i;
  logic signed [45:0]       q_i;

  // stage j
  logic signed [TEMP_W-1:0] temp_j;
  logic signed [47:0]       diff_j;

  logic signed [66:0] prod_adj;
  logic signed [47:0] diff_adj;
  logic signed [47:0] p_full;
  logic signed [PRES_W-1:0] p_sat;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      temp_g  <= s.temp;
      off_g   <= s.off;
      pp_lo_g <= 45'(s.d1) * 45'(s.sens[20:0]);
      pp_hi_g <= 46'($signed({1'b0, s.d1})) * 46'($signed(s.sens[41:21]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      temp_h <= temp_g;
      off_h  <= off_g;
      prod_h <= (67'(pp_hi_g) <<< 21) + $signed({22'd0, pp_lo_g});
    end
  end

  always_comb begin
    prod_adj = prod_h + (prod_h[66] ? 67'sd2097151 : 67'sd0);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      temp_i <= temp_h;
      off_i  <= off_h;
      q_i    <= 46'(prod_adj >>> 21);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      temp_j <= temp_i;
      diff_j <= 48'(q_i) - 48'(off_i);
    end
  end

  always_comb begin
    diff_adj = diff_j + (diff_j[47] ? 48'sd8191 : 48'sd0);
    p_full   = diff_adj >>> 13;
    if (p_full > P_MAX) begin
      p_sat = P_MAX[PRES_W-1:0];
    end else if (p_full < P_MIN) begin
      p_sat = P_MIN[PRES_W-1:0];
    end else begin
      p_sat = p_full[PRES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      res.temperature_centi <= temp_j;
      res.pressure_decimbar <= p_sat;
    end
  end

endmodule

`default_nettype wire

// ----- design/pressure_sensor_compensation.sv -----
// pressure_sensor_compensation: top level, calibration registers and the
// eleven-stage compensation pipeline
// depends on psc_pkg, psc_ctrl, psc_first, psc_second, psc_press
//
//   channel   direction  handshake             payload
//   cfg       in         cfg_write             cfg_index, cfg_data
//   in        in         in_valid / in_ready   in_data (raw pressure, raw temperature)
//   out       out        out_valid / out_ready out_data (temperature, pressure)
//
// one conversion pair per cycle while out_ready stays high; each pair passes
// through the eleven register stages of the datapath
// reset clears the stage valid bits and the six calibration words
// each stage holds while it is full and the next stage holds; empty stages
// keep filling, so in_ready stays high while a bubble is left
`default_nettype none

module pressure_sensor_compensation (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [psc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psc_pkg::CAL_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  psc_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output psc_pkg::out_t                    out_data
);
  import psc_pkg::*;

  cal_t                  cal;
  logic [NUM_STAGES-1:0] en;
  first_t                first_res;
  second_t               second_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PRESS_SENS: cal.press_sens <= cfg_data;
        REG_PRESS_OFF:  cal.press_off  <= cfg_data;
        REG_SENS_TC:    cal.sens_tc    <= cfg_data;
        REG_OFF_TC:     cal.off_tc     <= cfg_data;
        REG_TEMP_REF:   cal.temp_ref   <= cfg_data;
        REG_TEMP_COEFF: cal.temp_coeff <= cfg_data;
        default: ;
      endcase
    end
  end

  psc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .en        (en)
  );

  psc_first u_first (
    .clk     (clk),
    .en      (en[FIRST_STAGES-1:0]),
    .in_data (in_data),
    .cal     (cal),
    .res     (first_res)
  );

  psc_second u_second (
    .clk (clk),
    .en  (en[FIRST_STAGES+SECOND_STAGES-1:FIRST_STAGES]),
    .f   (first_res),
    .res (second_res)
  );

  psc_press u_press (
    .clk (clk),
    .en  (en[NUM_STAGES-1:FIRST_STAGES+SECOND_STAGES]),
    .s   (second_res),
    .res (out_data)
  );

endmodule

`default_nettype wire

// ----- verif/pressure_sensor_compensation_tb.sv -----
// pressure_sensor_compensation_tb: self-checking bench for the compensation block,
// directed band corners then random conversion pairs over several calibration sets
// depends on psc_pkg and pressure_sensor_compensation
`timescale 1ns / 100ps

module pressure_sensor_compensation_tb;
  import psc_pkg::*;

  localparam int NUM_CAL_WORDS = 6;
  localparam int RAW_MAX = 2**RAW_W - 1;
  localparam logic [CAL_W-1:0] CAL_MAX = '1;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_PHASES = 8;
  localparam int PAIRS_PER_PHASE = 125;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CAL_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  logic [CAL_W-1:0] cal_words [NUM_CAL_WORDS];
  in_t pending_conversions [$];
  out_t expected_readings [$];
  bit idle_on = 1'b0;
  int in_wait = 0;
  int out_wait = 0;
  int fail_count = 0;
  int cycle_count = 0;

  pressure_sensor_compensation DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int draw_wait();
    return idle_on ? $urandom_range(0, 10) : 0;
  endfunction

  // second-order compensation in 64-bit signed arithmetic, truncating divisions
  function automatic out_t compensate(in_t conv);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, t, tm, tp, off, sens, ti, offi, sensi, p;
    out_t r;
    d1 = conv.raw_pressure;
    d2 = conv.raw_temperature;
    c1 = cal_words[REG_PRESS_SENS];
    c2 = cal_words[REG_PRESS_OFF];
    c3 = cal_words[REG_SENS_TC];
    c4 = cal_words[REG_OFF_TC];
    c5 = cal_words[REG_TEMP_REF];
    c6 = cal_words[REG_TEMP_COEFF];
    dt = d2 - c5 * 256;
    t = TEMP_HIGH_LIMIT + dt * c6 / 8388608;
    off = c2 * 65536 + c4 * dt / 128;
    sens = c1 * 32768 + c3 * dt / 256;
    tm = t - TEMP_HIGH_LIMIT;
    tp = t - TEMP_VLOW_LIMIT;
    if (t < TEMP_HIGH_LIMIT) begin
      ti = 3 * dt * dt / 64'sd8589934592;
      offi = 3 * tm * tm / 2;
      sensi = 5 * tm * tm / 8;
      if (t < TEMP_VLOW_LIMIT) begin
        offi += 7 * tp * tp;
        sensi += 4 * tp * tp;
      end
    end else begin
      ti = 2 * dt * dt / 64'sd137438953472;
      offi = tm * tm / 16;
      sensi = 0;
    end
    t = t - ti;
    p = (d1 * (sens - sensi) / 2097152 - (off - offi)) / 8192;
    if (p > 64'sh7fff_ffff) p = 64'sh7fff_ffff;
    if (p < -64'sh8000_0000) p = -64'sh8000_0000;
    r.temperature_centi = t[TEMP_W-1:0];
    r.pressure_decimbar = p[PRES_W-1:0];
    return r;
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_wait = 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_readings.push_back(compensate(in_data));
      if (in_wait != 0) begin
        in_wait = in_wait - 1;
        in_valid <= 1'b0;
      end else if (pending_conversions.size() != 0) begin
        in_data <= pending_conversions.pop_front();
        in_valid <= 1'b1;
        in_wait = draw_wait();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      out_ready <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          $error("result transfer with nothing expected: temperature_centi %0d pressure_decimbar %0d",
                 out_data.temperature_centi, out_data.pressure_decimbar);
          fail_count++;
        end else begin
          want = expected_readings.pop_front();
          if (out_data.temperature_centi !== want.temperature_centi) begin
            $error("temperature_centi expected %0d actual %0d",
                   want.temperature_centi, out_data.temperature_centi);
            fail_count++;
          end
          if (out_data.pressure_decimbar !== want.pressure_decimbar) begin
            $error("pressure_decimbar expected %0d actual %0d",
                   want.pressure_decimbar, out_data.pressure_decimbar);
            fail_count++;
          end
        end
        out_wait = draw_wait();
      end
      if (out_wait != 0) begin
        out_wait = out_wait - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("pressure_sensor_compensation: mismatch");
      $finish;
    end
  end

  task automatic queue_pair(input int d1, input int d2);
    in_t conv;
    conv.raw_pressure = d1[RAW_W-1:0];
    conv.raw_temperature = d2[RAW_W-1:0];
    pending_conversions.push_back(conv);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_conversions.size() != 0 || in_valid || expected_readings.size() != 0);
    repeat (NUM_STAGES + 4) @(posedge clk);
  endtask

  task automatic write_cal(input int idx, input logic [CAL_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_data <= value;
    if (idx < NUM_CAL_WORDS) cal_words[idx] = value;
  endtask

  task automatic load_cal(input logic [CAL_W-1:0] sens, off, sens_tc, off_tc, tref, tcoeff);
    wait_drained();
    write_cal(REG_PRESS_SENS, sens);
    write_cal(REG_PRESS_OFF, off);
    write_cal(REG_SENS_TC, sens_tc);
    write_cal(REG_OFF_TC, off_tc);
    write_cal(REG_TEMP_REF, tref);
    write_cal(REG_TEMP_COEFF, tcoeff);
    // unmapped index, must leave the calibration untouched
    write_cal(NUM_CAL_WORDS + $urandom_range(0, 2**CFG_IDX_W - 1 - NUM_CAL_WORDS),
              CAL_W'($urandom));
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [CAL_W-1:0] random_cal_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CAL_MAX;
      default: return CAL_W'($urandom);
    endcase
  endfunction

  initial begin
    // reference 32768*256 and coefficient 8192 give T = 2000 + dt/1024
    int band_ref;
    int band_points [7];
    int ref_raw, d2;
    band_ref = 32768 * 256;
    band_points = '{band_ref, band_ref - 1, band_ref - 1024, band_ref - 3584000,
                    band_ref - 3585024, 0, RAW_MAX};
    foreach (cal_words[i]) cal_words[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // calibration at reset values, raw field corners
    queue_pair(0, 0);
    queue_pair(RAW_MAX, 0);
    queue_pair(0, RAW_MAX);
    queue_pair(RAW_MAX, RAW_MAX);

    // band edges: high, low, very low and the boundaries between them
    load_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd32768, 16'd8192);
    idle_on = 1'b1;
    foreach (band_points[i]) begin
      queue_pair(0, band_points[i]);
      queue_pair(RAW_MAX, band_points[i]);
    end
    queue_pair(24'h555555, band_ref);
    queue_pair(24'haaaaaa, band_ref - 3585024);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: load_cal(CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX);
        1: load_cal('0, '0, '0, '0, '0, '0);
        default: load_cal(random_cal_word(), random_cal_word(), random_cal_word(),
                          random_cal_word(), random_cal_word(), random_cal_word());
      endcase
      idle_on = (phase % 3 != 2);
      ref_raw = cal_words[REG_TEMP_REF] * 256;
      for (int n = 0; n < PAIRS_PER_PHASE; n++) begin
        case ($urandom_range(0, 3))
          0, 1: d2 = $urandom_range(0, RAW_MAX);
          2: d2 = ref_raw + $urandom_range(0, 2 * 65536) - 65536;
          default: d2 = ref_raw - $urandom_range(0, 1 << 22);
        endcase
        if (d2 < 0) d2 = 0;
        if (d2 > RAW_MAX) d2 = RAW_MAX;
        queue_pair($urandom_range(0, RAW_MAX), d2);
      end
    end

    wait_drained();
    if (expected_readings.size() != 0) begin
      $error("%0d results never arrived", expected_readings.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("pressure_sensor_compensation: match");
    end else begin
      $display("pressure_sensor_compensation: mismatch");
    end
    $finish;
  end

endmodule
